FILE: rtl/core/lph_pkg.sv
package lph_pkg;

  localparam int unsigned SlotsPerBank = 1031;
  localparam int unsigned RamDepth     = 2 * SlotsPerBank;
  localparam int unsigned AddrW        = $clog2(RamDepth);
  localparam int unsigned IdxW         = $clog2(SlotsPerBank + 1);
  localparam int unsigned StepW        = 4;
  localparam int unsigned CountW       = 10;
  localparam int unsigned KeyW         = 64;
  localparam int unsigned LenW         = 4;
  localparam int unsigned ValW         = 32;
  localparam int unsigned MaxKeyBytes  = 8;
  localparam int unsigned HashW        = 32;

  localparam logic [StepW-1:0] TopStep = StepW'(8);

  // opcodes
  localparam logic [1:0] OpLookup = 2'd0;
  localparam logic [1:0] OpInsert = 2'd1;
  localparam logic [1:0] OpDelete = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  // status codes
  localparam logic [2:0] StFound    = 3'd0;
  localparam logic [2:0] StNotFound = 3'd1;
  localparam logic [2:0] StUpdated  = 3'd2;
  localparam logic [2:0] StInserted = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [KeyW-1:0]        key_bytes;
    logic [LenW-1:0]        key_length;
    logic signed [ValW-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic [2:0]             status;
    logic signed [ValW-1:0] found_value;
    logic [CountW-1:0]      entries_held;
  } res_t;

  typedef struct packed {
    logic            valid;
    logic [LenW-1:0] len;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] data;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

  // prime ladder
  function automatic logic [IdxW-1:0] ladder_size(input logic [StepW-1:0] step);
    logic [IdxW-1:0] s;
    case (step)
      4'd0:    s = IdxW'(5);
      4'd1:    s = IdxW'(7);
      4'd2:    s = IdxW'(17);
      4'd3:    s = IdxW'(31);
      4'd4:    s = IdxW'(67);
      4'd5:    s = IdxW'(131);
      4'd6:    s = IdxW'(257);
      4'd7:    s = IdxW'(521);
      default: s = IdxW'(1031);
    endcase
    return s;
  endfunction

  // 17/20 of each ladder size
  function automatic logic [CountW-1:0] fill_limit(input logic [StepW-1:0] step);
    logic [CountW-1:0] f;
    case (step)
      4'd0:    f = CountW'(4);
      4'd1:    f = CountW'(5);
      4'd2:    f = CountW'(14);
      4'd3:    f = CountW'(26);
      4'd4:    f = CountW'(56);
      4'd5:    f = CountW'(111);
      4'd6:    f = CountW'(218);
      4'd7:    f = CountW'(442);
      default: f = CountW'(876);
    endcase
    return f;
  endfunction

endpackage

FILE: rtl/core/lph_ram.sv
module lph_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/lph_hash.sv
module lph_hash (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lph_pkg::KeyW-1:0]  key_i,
  input  logic [lph_pkg::LenW-1:0]  len_i,
  input  logic [lph_pkg::IdxW-1:0]  size_i,
  output logic                      done_o,
  output logic [lph_pkg::IdxW-1:0]  idx_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhHash = 2'd1;
  localparam logic [1:0] PhMod  = 2'd2;

  logic [1:0]                   phase_q, phase_d;
  logic [lph_pkg::LenW-1:0]     bcnt_q, bcnt_d;
  logic [4:0]                   mcnt_q, mcnt_d;
  logic [lph_pkg::HashW-1:0]    h_q, h_d;
  logic [lph_pkg::IdxW-1:0]     r_q, r_d;
  logic [lph_pkg::KeyW-1:0]     key_q, key_d;
  logic [lph_pkg::LenW-1:0]     len_q, len_d;
  logic [lph_pkg::IdxW-1:0]     size_q, size_d;
  logic                         done_q, done_d;
  logic [lph_pkg::HashW-1:0]    hs, g;
  logic [lph_pkg::IdxW:0]       t;

  always_comb begin
    phase_d = phase_q;
    bcnt_d  = bcnt_q;
    mcnt_d  = mcnt_q;
    h_d     = h_q;
    r_d     = r_q;
    key_d   = key_q;
    len_d   = len_q;
    size_d  = size_q;
    done_d  = 1'b0;
    // one byte step of the pjw hash
    hs = (h_q << 4) + {24'd0, key_q[7:0]};
    g  = hs & 32'hF000_0000;
    if (g != '0) begin
      hs = hs ^ (g >> 24) ^ g;
    end
    // one restoring step of the modulo
    t = {r_q, h_q[mcnt_q]};
    case (phase_q)
      PhIdle: begin
        if (start_i) begin
          phase_d = PhHash;
          bcnt_d  = '0;
          h_d     = '0;
          key_d   = key_i;
          len_d   = len_i;
          size_d  = size_i;
        end
      end
      PhHash: begin
        if (bcnt_q == len_q) begin
          phase_d = PhMod;
          mcnt_d  = 5'd31;
          r_d     = '0;
        end else begin
          h_d    = hs;
          key_d  = key_q >> 8;
          bcnt_d = bcnt_q + 1'b1;
        end
      end
      PhMod: begin
        if (t >= {1'b0, size_q}) begin
          r_d = lph_pkg::IdxW'(t - {1'b0, size_q});
        end else begin
          r_d = t[lph_pkg::IdxW-1:0];
        end
        mcnt_d = mcnt_q - 1'b1;
        if (mcnt_q == '0) begin
          phase_d = PhIdle;
          done_d  = 1'b1;
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcnt_q <= bcnt_d;
    mcnt_q <= mcnt_d;
    h_q    <= h_d;
    r_q    <= r_d;
    key_q  <= key_d;
    len_q  <= len_d;
    size_q <= size_d;
  end

  assign done_o = done_q;
  assign idx_o  = r_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> phase_q == PhIdle) else $error("hash done outside idle");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> r_q < size_q) else $error("remainder out of range");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> phase_q == PhIdle) else $error("hash started while busy");

endmodule

FILE: rtl/core/linear_probe_hash_map.sv
// after reset a clearing pass over every slot of both banks runs with busy high
// per item: a byte-wise hash of the key, a bit-serial modulo, then a probe slot by slot
// a delete adds a rehash of each later entry of the cluster; a growing insert adds
// a sweep of the new bank plus a rehash of every entry; one item at a time, busy while working
// one result word per item, strobed by done_o for one cycle; the receiver cannot stall
// asynchronous active-low reset empties the map and returns to size 5
module linear_probe_hash_map (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  lph_pkg::req_t   in_i,
  output logic            done_o,
  output lph_pkg::res_t   res_o
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_GCLR   = 4'd2;
  localparam logic [3:0] S_GRD    = 4'd3;
  localparam logic [3:0] S_GCHK   = 4'd4;
  localparam logic [3:0] S_GPLACE = 4'd5;
  localparam logic [3:0] S_HASH   = 4'd6;
  localparam logic [3:0] S_PRD    = 4'd7;
  localparam logic [3:0] S_PCHK   = 4'd8;
  localparam logic [3:0] S_OP     = 4'd9;
  localparam logic [3:0] S_DNEXT  = 4'd10;
  localparam logic [3:0] S_DCHK   = 4'd11;
  localparam logic [3:0] S_DPLACE = 4'd12;

  localparam int unsigned IdxW = lph_pkg::IdxW;
  localparam int unsigned AddrW = lph_pkg::AddrW;

  logic [3:0]                   state_q, state_d, ret_q, ret_d;
  logic [AddrW-1:0]             cnt_q, cnt_d;
  logic [1:0]                   op_q, op_d;
  logic [lph_pkg::KeyW-1:0]     key_q, key_d, w_key_q, w_key_d;
  logic [lph_pkg::LenW-1:0]     len_q, len_d, w_len_q, w_len_d;
  logic [lph_pkg::ValW-1:0]     val_q, val_d, w_data_q, w_data_d, hdata_q, hdata_d;
  logic                         pbank_q, pbank_d, bank_q, bank_d;
  logic [IdxW-1:0]              psize_q, psize_d, idx_q, idx_d, pn_q, pn_d;
  logic [IdxW-1:0]              at_q, at_d, j_q, j_d;
  logic                         hit_q, hit_d, none_q, none_d, hstart_q, hstart_d;
  logic [lph_pkg::StepW-1:0]    step_q, step_d;
  logic [lph_pkg::CountW-1:0]   count_q, count_d;
  lph_pkg::res_t                res_q, res_d;
  logic                         done_q, done_d;

  logic                         we, re;
  logic [AddrW-1:0]             waddr, raddr;
  lph_pkg::slot_t               wdata, rdata;
  logic [lph_pkg::SlotW-1:0]    rdata_raw;
  logic                         h_done;
  logic [IdxW-1:0]              h_idx;
  logic [IdxW-1:0]              cur_size, new_size, jn;
  logic [lph_pkg::LenW-1:0]     len_sat;
  logic [lph_pkg::KeyW-1:0]     key_m;
  logic                         match;

  // bank and slot index to memory address
  function automatic logic [AddrW-1:0] slot_addr(input logic bank, input logic [IdxW-1:0] i);
    if (bank) begin
      return AddrW'(lph_pkg::SlotsPerBank) + AddrW'(i);
    end
    return AddrW'(i);
  endfunction

  assign cur_size = lph_pkg::ladder_size(step_q);
  assign new_size = lph_pkg::ladder_size(step_q + 1'b1);
  assign rdata    = lph_pkg::slot_t'(rdata_raw);
  assign match    = (rdata.len == w_len_q) && (rdata.key == w_key_q);
  assign jn       = (j_q == psize_q - 1'b1) ? '0 : j_q + 1'b1;

  // saturate length and mask the unused key bytes
  always_comb begin
    len_sat = (in_i.key_length > lph_pkg::LenW'(lph_pkg::MaxKeyBytes)) ?
              lph_pkg::LenW'(lph_pkg::MaxKeyBytes) : in_i.key_length;
    for (int b = 0; b < 8; b++) begin
      key_m[8*b +: 8] = (lph_pkg::LenW'(b) < len_sat) ? in_i.key_bytes[8*b +: 8] : 8'd0;
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    cnt_d    = cnt_q;
    op_d     = op_q;
    key_d    = key_q;
    len_d    = len_q;
    val_d    = val_q;
    w_key_d  = w_key_q;
    w_len_d  = w_len_q;
    w_data_d = w_data_q;
    hdata_d  = hdata_q;
    pbank_d  = pbank_q;
    bank_d   = bank_q;
    psize_d  = psize_q;
    idx_d    = idx_q;
    pn_d     = pn_q;
    at_d     = at_q;
    j_d      = j_q;
    hit_d    = hit_q;
    none_d   = none_q;
    hstart_d = 1'b0;
    step_d   = step_q;
    count_d  = count_q;
    res_d    = res_q;
    done_d   = 1'b0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    re       = 1'b0;
    raddr    = '0;

    case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = cnt_q;
        if (cnt_q == AddrW'(lph_pkg::RamDepth - 1)) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_d  = in_i.opcode;
          key_d = key_m;
          len_d = len_sat;
          val_d = in_i.new_value;
          if (in_i.opcode == lph_pkg::OpInsert &&
              count_q >= lph_pkg::fill_limit(step_q) && step_q < lph_pkg::TopStep) begin
            cnt_d   = '0;
            state_d = S_GCLR;
          end else begin
            w_key_d  = key_m;
            w_len_d  = len_sat;
            pbank_d  = bank_q;
            psize_d  = cur_size;
            hstart_d = 1'b1;
            ret_d    = S_OP;
            state_d  = S_HASH;
          end
        end
      end
      // sweep the other bank empty
      S_GCLR: begin
        we    = 1'b1;
        waddr = slot_addr(!bank_q, cnt_q[IdxW-1:0]);
        if (cnt_q[IdxW-1:0] == new_size - 1'b1) begin
          cnt_d   = '0;
          state_d = S_GRD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      // walk the old bank
      S_GRD: begin
        if (cnt_q[IdxW-1:0] == cur_size) begin
          step_d   = step_q + 1'b1;
          bank_d   = !bank_q;
          w_key_d  = key_q;
          w_len_d  = len_q;
          pbank_d  = !bank_q;
          psize_d  = new_size;
          hstart_d = 1'b1;
          ret_d    = S_OP;
          state_d  = S_HASH;
        end else begin
          re      = 1'b1;
          raddr   = slot_addr(bank_q, cnt_q[IdxW-1:0]);
          state_d = S_GCHK;
        end
      end
      S_GCHK: begin
        if (rdata.valid) begin
          w_key_d  = rdata.key;
          w_len_d  = rdata.len;
          w_data_d = rdata.data;
          pbank_d  = !bank_q;
          psize_d  = new_size;
          hstart_d = 1'b1;
          ret_d    = S_GPLACE;
          state_d  = S_HASH;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_GRD;
        end
      end
      S_GPLACE: begin
        if (!none_q) begin
          we    = 1'b1;
          waddr = slot_addr(pbank_q, at_q);
          wdata = '{valid: 1'b1, len: w_len_q, key: w_key_q, data: w_data_q};
        end
        cnt_d   = cnt_q + 1'b1;
        state_d = S_GRD;
      end
      // probe subroutine
      S_HASH: begin
        if (h_done) begin
          idx_d   = h_idx;
          pn_d    = '0;
          state_d = S_PRD;
        end
      end
      S_PRD: begin
        re      = 1'b1;
        raddr   = slot_addr(pbank_q, idx_q);
        state_d = S_PCHK;
      end
      S_PCHK: begin
        if (!rdata.valid) begin
          hit_d   = 1'b0;
          none_d  = 1'b0;
          at_d    = idx_q;
          state_d = ret_q;
        end else if (match) begin
          hit_d   = 1'b1;
          none_d  = 1'b0;
          at_d    = idx_q;
          hdata_d = rdata.data;
          state_d = ret_q;
        end else if (pn_q == psize_q - 1'b1) begin
          hit_d   = 1'b0;
          none_d  = 1'b1;
          state_d = ret_q;
        end else begin
          pn_d    = pn_q + 1'b1;
          idx_d   = (idx_q == psize_q - 1'b1) ? '0 : idx_q + 1'b1;
          state_d = S_PRD;
        end
      end
      // act on the probe outcome
      S_OP: begin
        res_d.status       = lph_pkg::StNotFound;
        res_d.found_value  = '1;
        res_d.entries_held = count_q;
        state_d            = S_IDLE;
        done_d             = 1'b1;
        case (op_q)
          lph_pkg::OpLookup: begin
            if (hit_q) begin
              res_d.status      = lph_pkg::StFound;
              res_d.found_value = hdata_q;
            end
          end
          lph_pkg::OpInsert: begin
            if (hit_q) begin
              we    = 1'b1;
              waddr = slot_addr(pbank_q, at_q);
              wdata = '{valid: 1'b1, len: len_q, key: key_q, data: val_q};
              res_d.status = lph_pkg::StUpdated;
            end else if (count_q >= lph_pkg::fill_limit(step_q) || none_q) begin
              res_d.status = lph_pkg::StFull;
            end else begin
              we    = 1'b1;
              waddr = slot_addr(pbank_q, at_q);
              wdata = '{valid: 1'b1, len: len_q, key: key_q, data: val_q};
              count_d            = count_q + 1'b1;
              res_d.status       = lph_pkg::StInserted;
              res_d.entries_held = count_q + 1'b1;
            end
          end
          lph_pkg::OpDelete: begin
            if (hit_q) begin
              we      = 1'b1;
              waddr   = slot_addr(pbank_q, at_q);
              count_d = count_q - 1'b1;
              j_d     = at_q;
              cnt_d   = '0;
              state_d = S_DNEXT;
              done_d  = 1'b0;
            end
          end
          default: ;
        endcase
      end
      // pull out and re-place the rest of the cluster
      S_DNEXT: begin
        if (cnt_q[IdxW-1:0] == psize_q) begin
          res_d.status       = lph_pkg::StFound;
          res_d.found_value  = '1;
          res_d.entries_held = count_q;
          done_d             = 1'b1;
          state_d            = S_IDLE;
        end else begin
          j_d     = jn;
          cnt_d   = cnt_q + 1'b1;
          re      = 1'b1;
          raddr   = slot_addr(bank_q, jn);
          state_d = S_DCHK;
        end
      end
      S_DCHK: begin
        if (!rdata.valid) begin
          res_d.status       = lph_pkg::StFound;
          res_d.found_value  = '1;
          res_d.entries_held = count_q;
          done_d             = 1'b1;
          state_d            = S_IDLE;
        end else begin
          we       = 1'b1;
          waddr    = slot_addr(bank_q, j_q);
          w_key_d  = rdata.key;
          w_len_d  = rdata.len;
          w_data_d = rdata.data;
          pbank_d  = bank_q;
          psize_d  = cur_size;
          hstart_d = 1'b1;
          ret_d    = S_DPLACE;
          state_d  = S_HASH;
        end
      end
      S_DPLACE: begin
        if (!none_q) begin
          we    = 1'b1;
          waddr = slot_addr(pbank_q, at_q);
          wdata = '{valid: 1'b1, len: w_len_q, key: w_key_q, data: w_data_q};
        end
        state_d = S_DNEXT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      ret_q    <= S_OP;
      cnt_q    <= '0;
      step_q   <= '0;
      bank_q   <= 1'b0;
      count_q  <= '0;
      hstart_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      cnt_q    <= cnt_d;
      step_q   <= step_d;
      bank_q   <= bank_d;
      count_q  <= count_d;
      hstart_q <= hstart_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    len_q    <= len_d;
    val_q    <= val_d;
    w_key_q  <= w_key_d;
    w_len_q  <= w_len_d;
    w_data_q <= w_data_d;
    hdata_q  <= hdata_d;
    pbank_q  <= pbank_d;
    psize_q  <= psize_d;
    idx_q    <= idx_d;
    pn_q     <= pn_d;
    at_q     <= at_d;
    j_q      <= j_d;
    hit_q    <= hit_d;
    none_q   <= none_d;
    res_q    <= res_d;
  end

  // shared hash and modulo unit
  lph_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hstart_q),
    .key_i  (w_key_q),
    .len_i  (w_len_q),
    .size_i (psize_q),
    .done_o (h_done),
    .idx_o  (h_idx)
  );

  // slot storage, both banks
  lph_ram #(
    .Width(lph_pkg::SlotW),
    .Depth(lph_pkg::RamDepth)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy) else $error("result word while busy");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lph_pkg::fill_limit(lph_pkg::TopStep)) else $error("entry count overflow");
  a_step_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= lph_pkg::TopStep) else $error("size step past top");

endmodule
